// ===== hw/rtl/ftms_pkg.sv =====
// ----------------------------------------------------------------------------
// ftms_pkg
// shared types and constants of the fan tach monitor and selector
// ----------------------------------------------------------------------------
package ftms_pkg;

  localparam int unsigned PULSES_PER_REV_DEF = 2;
  localparam int unsigned NUM_FANS           = 3;
  localparam int unsigned CFG_W              = 16;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_SPEED_RST   = 16'd0;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 16'd65535;
  localparam logic [CFG_W-1:0] START_DELAY_RST = 16'd300;
  localparam logic [CFG_W-1:0] GAP_DELAY_RST   = 16'd10;

  typedef enum logic [1:0] {
    REG_MIN_SPEED   = 2'd0,
    REG_MAX_SPEED   = 2'd1,
    REG_START_DELAY = 2'd2,
    REG_GAP_DELAY   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_FAN0  = 3'd1,
    PH_FAN1  = 3'd2,
    PH_FAN2  = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] pulse_count;
    logic        fan1_on;
    logic        fan2_on;
    logic        fan3_on;
  } item_t;

  typedef struct packed {
    logic [2:0] fault_flags;
    logic [1:0] selected_fan;
    logic [1:0] route_fan;
    logic       measure_taken;
    logic       alarm_clear;
    logic       round_done;
  } result_t;

endpackage

// ===== hw/rtl/ftms_judge.sv =====
// ----------------------------------------------------------------------------
// ftms_judge
// checks one tach reading against the speed window for the fan's on state
// ----------------------------------------------------------------------------
module ftms_judge #(
  parameter int unsigned PULSES_PER_REV = ftms_pkg::PULSES_PER_REV_DEF
) (
  input  logic [15:0]              pulses,
  input  logic                     fan_on,
  input  logic [ftms_pkg::CFG_W-1:0] min_speed,
  input  logic [ftms_pkg::CFG_W-1:0] max_speed,
  output logic                     fault
);
  import ftms_pkg::*;

  // speed = pulses / ppr is never formed: the limits are scaled by ppr instead
  localparam int unsigned PprW = $clog2(PULSES_PER_REV + 1);
  localparam int unsigned LimW = CFG_W + 1 + PprW;

  logic [LimW-1:0] ppr_w;
  logic [LimW-1:0] pulses_w;
  logic [LimW-1:0] low_w;
  logic [LimW-1:0] above_low_thr;
  logic [LimW-1:0] below_high_thr;
  logic [LimW-1:0] off_thr;

  assign ppr_w    = LimW'(PULSES_PER_REV);
  assign pulses_w = LimW'(pulses);
  assign low_w    = LimW'(min_speed[CFG_W-1:1]);

  // speed > low  <=>  pulses >= (low + 1) * ppr
  assign above_low_thr  = (low_w + LimW'(1)) * ppr_w;
  // speed < 2*max  <=>  pulses < 2*max * ppr
  assign below_high_thr = LimW'({max_speed, 1'b0}) * ppr_w;
  // speed < low  <=>  pulses < low * ppr
  assign off_thr        = low_w * ppr_w;

  always_comb begin
    if (fan_on) begin
      fault = !((pulses_w >= above_low_thr) && (pulses_w < below_high_thr));
    end else begin
      fault = !(pulses_w < off_thr);
    end
  end

endmodule

// ===== hw/rtl/fan_tach_monitor_selector_top.sv =====
// ----------------------------------------------------------------------------
// fan_tach_monitor_selector_top
// tick driven tach monitor for three fans with round-robin working-fan pick
// ----------------------------------------------------------------------------
// usage
//   each transaction on the item channel is one tick: the pulse count of the
//   fan routed for measurement and the on command of each fan. every item
//   gives exactly one result transaction carrying the fault flags, selected
//   fan, routed fan and the measure / round-done / alarm-clear strobes.
//   a round waits start_delay ticks, measures fans 0, 1, 2 with gap_delay
//   ticks after each, then concludes with the round-robin pick.
//   configuration is a plain write port (cfg_we, cfg_index, cfg_data); the
//   user writes it only while no transaction is in flight, the block does not enforce it.
// timing
//   result_valid rises after the input register and one pass of compare and
//   select logic into the result register, which also updates the running
//   state. one item per cycle is sustained without result stalls; the speed
//   window check (constant multiply and compare) sets the path.
// reset
//   rst is synchronous; it empties both registers and returns the sequencer
//   to the start phase with no faults, fan 0 selected and the pointer at 0.
// stall
//   a stalled result holds; the input register still takes one more item,
//   after which item_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module fan_tach_monitor_selector_top #(
  parameter int unsigned PULSES_PER_REV = ftms_pkg::PULSES_PER_REV_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ftms_pkg::CFG_W-1:0] cfg_data,
  // item channel
  input  logic                       item_valid,
  output logic                       item_stall,
  input  ftms_pkg::item_t            item,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output ftms_pkg::result_t          result
);
  import ftms_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] min_speed;
  logic [CFG_W-1:0] max_speed;
  logic [CFG_W-1:0] start_delay;
  logic [CFG_W-1:0] gap_delay;

  // running state
  phase_t      phase, phase_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic [2:0]  fault_bits, fault_bits_next;
  logic [1:0]  chosen_fan, chosen_fan_next;
  logic [2:0]  scan_pointer, scan_pointer_next;

  // input register
  logic  hold_valid;
  item_t hold;

  // pipeline control
  logic advance;
  logic accept;
  logic step;

  // step logic
  logic [1:0] meas_fan;
  logic       meas_on;
  logic       meas_fault;
  logic [2:0] fans_on;
  result_t    result_next;
  logic [1:0] start_idx;
  logic       found;
  logic [1:0] pick;

  // ------------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed   <= MIN_SPEED_RST;
      max_speed   <= MAX_SPEED_RST;
      start_delay <= START_DELAY_RST;
      gap_delay   <= GAP_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_SPEED:   min_speed   <= cfg_data;
        REG_MAX_SPEED:   max_speed   <= cfg_data;
        REG_START_DELAY: start_delay <= cfg_data;
        REG_GAP_DELAY:   gap_delay   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // handshake: result register empties or drains, input register refills
  // ------------------------------------------------------------------------
  assign advance    = !result_valid || !result_stall;
  assign step       = hold_valid && advance;
  assign item_stall = hold_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
  end

  // ------------------------------------------------------------------------
  // measurement of the fan the phase points at
  // ------------------------------------------------------------------------
  assign fans_on  = {hold.fan3_on, hold.fan2_on, hold.fan1_on};
  assign meas_fan = 2'(phase - PH_FAN0);
  assign meas_on  = fans_on[meas_fan];

  ftms_judge #(
    .PULSES_PER_REV(PULSES_PER_REV)
  ) u_judge (
    .pulses    (hold.pulse_count),
    .fan_on    (meas_on),
    .min_speed (min_speed),
    .max_speed (max_speed),
    .fault     (meas_fault)
  );

  // round-robin search from the pointer for the first fan without a fault
  always_comb begin
    start_idx = (scan_pointer >= 3'd3) ? 2'd0 : scan_pointer[1:0];
    found     = 1'b0;
    pick      = chosen_fan;
    for (int i = 0; i < NUM_FANS; i++) begin
      if (!found && (2'(i) >= start_idx) && !fault_bits[i]) begin
        found = 1'b1;
        pick  = 2'(i);
      end
    end
  end

  // ------------------------------------------------------------------------
  // sequencer: next state and result of one tick
  // ------------------------------------------------------------------------
  always_comb begin
    phase_next        = phase;
    wait_timer_next   = wait_timer;
    fault_bits_next   = fault_bits;
    chosen_fan_next   = chosen_fan;
    scan_pointer_next = scan_pointer;
    result_next       = '0;
    result_next.route_fan = chosen_fan;

    unique case (phase)
      PH_START: begin
        wait_timer_next = start_delay;
        phase_next      = PH_FAN0;
      end
      PH_FAN0, PH_FAN1, PH_FAN2: begin
        if (wait_timer != 16'd0) begin
          wait_timer_next = wait_timer - 16'd1;
        end else begin
          fault_bits_next[meas_fan] = meas_fault;
          result_next.route_fan     = meas_fan;
          result_next.measure_taken = 1'b1;
          wait_timer_next           = gap_delay;
          phase_next                = phase_t'(phase + 3'd1);
        end
      end
      PH_DONE: begin
        if (wait_timer != 16'd0) begin
          wait_timer_next = wait_timer - 16'd1;
        end else begin
          // no healthy fan: keep the choice, restart the next scan at fan 0
          if (found) begin
            chosen_fan_next   = pick;
            scan_pointer_next = 3'(pick) + 3'd1;
          end else begin
            scan_pointer_next = 3'd4;
          end
          result_next.alarm_clear = ($countones(fault_bits) <= 1) &&
                                    ($countones(fans_on) >= 2);
          result_next.round_done  = 1'b1;
          result_next.route_fan   = found ? pick : chosen_fan;
          phase_next              = PH_START;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    result_next.fault_flags  = fault_bits_next;
    result_next.selected_fan = chosen_fan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      wait_timer   <= '0;
      fault_bits   <= '0;
      chosen_fan   <= '0;
      scan_pointer <= '0;
    end else if (step) begin
      phase        <= phase_next;
      wait_timer   <= wait_timer_next;
      fault_bits   <= fault_bits_next;
      chosen_fan   <= chosen_fan_next;
      scan_pointer <= scan_pointer_next;
    end
  end

  // ------------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  // input side only stalls when both registers are full and the output waits
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (hold_valid && result_valid && result_stall))
    else $error("item_stall raised with room in the pipeline");

  // a measurement tick never concludes a round
  a_measure_not_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.measure_taken) |-> !result.round_done)
    else $error("measurement and round conclusion in one transaction");

  // alarm clear is only given on a conclusion tick
  a_clear_on_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.alarm_clear) |-> result.round_done)
    else $error("alarm clear outside a round conclusion");

  // chosen and routed fans stay within the three fans
  a_fan_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.selected_fan != 2'd3 && result.route_fan != 2'd3))
    else $error("fan index out of range");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the three-fan tach monitor and working-fan selector
// ----------------------------------------------------------------------------
// every tick transaction is run through a cycle-free copy of the sequencer,
// the speed window judge and the round-robin pick. the copy keeps its own
// state and register values. each result transaction is compared field by
// field with the oldest prediction. the run walks through several register
// settings, the extremes among them. it starts with hand-built rounds, then feeds
// random ticks that track the round schedule: most measured counts match the fan
// command, some sit on window edges; sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;

  import ftms_pkg::*;

  localparam int unsigned PPR         = PULSES_PER_REV_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_TICKS = 8;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // block inputs, all known from time zero
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_index    = REG_MIN_SPEED;
  logic [15:0] cfg_data    = '0;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;

  fan_tach_monitor_selector_top #(
    .PULSES_PER_REV(PPR)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // register copies, at their reset values
  logic [15:0] cfg_min   = MIN_SPEED_RST;
  logic [15:0] cfg_max   = MAX_SPEED_RST;
  logic [15:0] cfg_start = START_DELAY_RST;
  logic [15:0] cfg_gap   = GAP_DELAY_RST;

  // sequencer state of the predictor
  phase_t      pred_phase   = PH_START;
  logic [15:0] pred_timer   = '0;
  logic [2:0]  pred_faults  = '0;
  logic [1:0]  pred_chosen  = '0;
  logic [2:0]  pred_pointer = '0;

  // look-ahead copy of the schedule, used only to aim the random counts
  phase_t      gen_phase = PH_START;
  logic [15:0] gen_timer = '0;
  logic [2:0]  fan_cmd   = 3'b111;

  item_t   pending_ticks[$];
  result_t expected_results[$];
  result_t want_result;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;
  int unsigned tick_count  = 0;
  int unsigned measure_count = 0;
  int unsigned round_count   = 0;
  int unsigned clear_count   = 0;
  int unsigned all_fault_count = 0;
  int unsigned settings_count  = 0;

  // speed window judge: an on fan must sit strictly inside the window,
  // an off fan strictly below the low limit
  function automatic logic fan_faulty(logic [15:0] pulses, logic on);
    int unsigned speed;
    int unsigned lo;
    int unsigned hi;
    speed = pulses / PPR;
    lo    = cfg_min >> 1;
    hi    = 32'(cfg_max) * 2;
    if (on) return !(speed > lo && speed < hi);
    return !(speed < lo);
  endfunction

  // advances the predicted sequencer by one tick and gives its result
  function automatic result_t fan_tick_predict(item_t tick);
    result_t     r;
    logic [2:0]  on;
    int          fan;
    int          p;
    logic        found;
    int unsigned nfault;
    int unsigned non;
    on = {tick.fan3_on, tick.fan2_on, tick.fan1_on};
    r = '0;
    r.route_fan = pred_chosen;
    case (pred_phase)
      PH_START: begin
        pred_timer = cfg_start;
        pred_phase = PH_FAN0;
      end
      PH_FAN0, PH_FAN1, PH_FAN2: begin
        if (pred_timer != 0) begin
          pred_timer = pred_timer - 1;
        end else begin
          fan = pred_phase - PH_FAN0;
          r.route_fan = 2'(fan);
          r.measure_taken = 1'b1;
          pred_faults[fan] = fan_faulty(tick.pulse_count, on[fan]);
          pred_timer = cfg_gap;
          pred_phase = phase_t'(pred_phase + 1);
        end
      end
      PH_DONE: begin
        if (pred_timer != 0) begin
          pred_timer = pred_timer - 1;
        end else begin
          // round-robin pick of the next healthy fan
          p = pred_pointer;
          if (p >= 3) p = 0;
          found = 1'b0;
          while (p < 3 && !found) begin
            if (!pred_faults[p]) begin
              found = 1'b1;
              pred_chosen = 2'(p);
            end else begin
              p++;
            end
          end
          pred_pointer = 3'(p + 1);
          nfault = $countones(pred_faults);
          non    = $countones(on);
          r.alarm_clear = (nfault <= 1 && non >= 2);
          r.round_done  = 1'b1;
          r.route_fan   = pred_chosen;
          pred_phase    = PH_START;
        end
      end
      default: pred_phase = PH_START;
    endcase
    r.fault_flags  = pred_faults;
    r.selected_fan = pred_chosen;
    return r;
  endfunction

  // random tick: follows the schedule so that a measured fan mostly gets a
  // count consistent with its command, sometimes one at a window edge, and
  // now and then plain noise
  function automatic item_t make_tick();
    item_t      t;
    logic [2:0] on;
    int         fan;
    int         lo;
    int         hi;
    int         top;
    int         spd;
    int         pick;
    int         pulse;
    fan = -1;
    if (gen_phase == PH_START) begin
      gen_timer = cfg_start;
      gen_phase = PH_FAN0;
    end else if (gen_timer != 0) begin
      gen_timer = gen_timer - 1;
    end else if (gen_phase == PH_DONE) begin
      gen_phase = PH_START;
    end else begin
      fan = gen_phase - PH_FAN0;
      gen_timer = cfg_gap;
      gen_phase = phase_t'(gen_phase + 1);
    end
    // fan commands drift slowly; a few ticks carry a random pattern
    if ($urandom_range(99) < 4) begin
      pick = $urandom_range(2);
      fan_cmd[pick] = ~fan_cmd[pick];
    end
    on = ($urandom_range(99) < 10) ? 3'($urandom) : fan_cmd;
    t.fan1_on = on[0];
    t.fan2_on = on[1];
    t.fan3_on = on[2];
    t.pulse_count = 16'($urandom);
    if (fan >= 0) begin
      lo   = int'(cfg_min) / 2;
      hi   = int'(cfg_max) * 2;
      top  = 65535 / PPR;
      pick = $urandom_range(99);
      spd  = -1;
      if (pick < 70) begin
        if (on[fan]) begin
          if (lo + 1 <= top && lo + 1 <= hi - 1)
            spd = $urandom_range((hi - 1 < top) ? hi - 1 : top, lo + 1);
        end else if (lo > 0) begin
          spd = $urandom_range(lo - 1, 0);
        end
      end else if (pick < 90) begin
        case ($urandom_range(7))
          0: spd = lo - 1;
          1: spd = lo;
          2: spd = lo + 1;
          3: spd = hi - 1;
          4: spd = hi;
          5: spd = hi + 1;
          6: spd = 0;
          default: spd = top;
        endcase
        if (spd < 0) spd = 0;
        if (spd > top) spd = top;
      end
      if (spd >= 0) begin
        pulse = spd * PPR + $urandom_range(PPR - 1);
        t.pulse_count = (pulse > 65535) ? 16'hFFFF : 16'(pulse);
      end
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one tick transaction per handshake, gaps drawn per cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // accepted at this edge, so predict now
      if (item_valid && !item_stall) begin
        expected_results.push_back(fan_tick_predict(item));
        tick_count++;
      end
      // a stalled transaction holds; otherwise offer the next one or idle
      if (!item_valid || !item_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item       <= pending_ticks.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: compares each taken result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("fault_flags", want_result.fault_flags, result.fault_flags);
          check_field("selected_fan", want_result.selected_fan, result.selected_fan);
          check_field("route_fan", want_result.route_fan, result.route_fan);
          check_field("measure_taken", want_result.measure_taken, result.measure_taken);
          check_field("alarm_clear", want_result.alarm_clear, result.alarm_clear);
          check_field("round_done", want_result.round_done, result.round_done);
          measure_count += result.measure_taken;
          round_count   += result.round_done;
          clear_count   += result.alarm_clear;
          if (result.round_done && result.fault_flags == 3'b111) all_fault_count++;
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one register write, mirrored into the predictor's copy
  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_MIN_SPEED:   cfg_min   = value;
      REG_MAX_SPEED:   cfg_max   = value;
      REG_START_DELAY: cfg_start = value;
      REG_GAP_DELAY:   cfg_gap   = value;
      default: ;
    endcase
  endtask

  // only called while nothing is in flight
  task automatic apply_config(logic [15:0] min_spd, logic [15:0] max_spd,
                              logic [15:0] start_dly, logic [15:0] gap_dly);
    write_reg(REG_MIN_SPEED, min_spd);
    write_reg(REG_MAX_SPEED, max_spd);
    write_reg(REG_START_DELAY, start_dly);
    write_reg(REG_GAP_DELAY, gap_dly);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_count++;
  endtask

  task automatic set_idling(int unsigned sender, int unsigned receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  // polled on the falling edge so that the clocked blocks have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || item_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // random ticks from the current predicted state; queue must be drained
  task automatic queue_random(int n);
    gen_phase = pred_phase;
    gen_timer = pred_timer;
    repeat (n) pending_ticks.push_back(make_tick());
  endtask

  // one full round with zero start and gap delay: start tick, three
  // measurements, conclusion
  task automatic push_round(logic [15:0] p0, logic [15:0] p1, logic [15:0] p2,
                            logic [2:0] on);
    item_t t;
    t.fan1_on = on[0];
    t.fan2_on = on[1];
    t.fan3_on = on[2];
    t.pulse_count = 16'hFFFF;
    pending_ticks.push_back(t);
    t.pulse_count = p0;
    pending_ticks.push_back(t);
    t.pulse_count = p1;
    pending_ticks.push_back(t);
    t.pulse_count = p2;
    pending_ticks.push_back(t);
    t.pulse_count = 16'h0000;
    pending_ticks.push_back(t);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // hand-built rounds, window 100 < speed < 2000, no delays
    apply_config(16'd200, 16'd1000, 16'd0, 16'd0);
    set_idling(0, 0);
    // all healthy: fan 0 picked, alarm clear
    push_round(16'd1000, 16'd1000, 16'd1000, 3'b111);
    // fan 0 stalled, off fan just under the low limit: pick moves on to fan 1
    push_round(16'd0, 16'd3999, 16'd199, 3'b011);
    // every fan over-speed: nothing to pick, pointer wraps to the start
    push_round(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
    // all off, third fan sits exactly on the low limit
    push_round(16'd0, 16'd1, 16'd200, 3'b000);
    // off fan just above the low limit, on fan exactly at the high limit
    push_round(16'd202, 16'd203, 16'd4000, 3'b110);
    wait_drained();

    // same window, random content at full rate
    queue_random(250);
    wait_drained();

    // widest window, short delays, sender gaps
    apply_config(16'd0, 16'hFFFF, 16'd3, 16'd1);
    set_idling(69, 0);
    queue_random(200);
    wait_drained();

    // empty window: an on fan always faults; receiver stalls
    apply_config(16'hFFFF, 16'd0, 16'd0, 16'd2);
    set_idling(0, 69);
    queue_random(200);
    wait_drained();

    // narrow window, both sides idling, with a full drain half way through
    apply_config(16'd300, 16'd300, 16'd1, 16'd0);
    set_idling(21, 21);
    queue_random(125);
    wait_drained();
    queue_random(125);
    wait_drained();

    // reset-value delays, one long round
    apply_config(16'd1000, 16'd20000, START_DELAY_RST, GAP_DELAY_RST);
    set_idling(0, 0);
    queue_random(350);
    wait_drained();

    // random window, idling mode changes while the rounds are running
    apply_config(16'($urandom_range(4000)), 16'($urandom_range(3000)), 16'd2, 16'd3);
    set_idling(0, 0);
    queue_random(300);
    while (pending_ticks.size() > 225) @(negedge clk);
    set_idling(69, 0);
    while (pending_ticks.size() > 150) @(negedge clk);
    set_idling(0, 69);
    while (pending_ticks.size() > 75) @(negedge clk);
    set_idling(21, 21);
    wait_drained();

    // longest delays: only the countdown is reached from here
    apply_config(16'd500, 16'd500, 16'hFFFF, 16'hFFFF);
    set_idling(21, 21);
    queue_random(60);
    wait_drained();

    repeat (DRAIN_TICKS) @(negedge clk);

    $display("run covered %0d ticks over %0d register settings: %0d measurements",
             tick_count, settings_count, measure_count);
    $display("%0d rounds concluded, %0d alarm clears, %0d rounds with every fan faulted",
             round_count, clear_count, all_fault_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
